FILE: rtl/core/isfd_pkg.sv
package isfd_pkg;

    localparam int PAYLOAD_BYTES_DEF = 36;
    localparam int WORD_COUNT_DEF    = 9;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int WORD_IDX_W  = 4;
    localparam int LANES       = WORD_W / BYTE_W;
    localparam int OUT_TDATA_W = ((WORD_W + WORD_IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - WORD_W - WORD_IDX_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HDR_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRL_FIRST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRL_SECOND = 2'd3;

    localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'h41;
    localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'h54;
    localparam logic [BYTE_W-1:0] TRL_FIRST_RST  = 8'h74;
    localparam logic [BYTE_W-1:0] TRL_SECOND_RST = 8'h61;

    typedef struct packed {
        logic clr_count;
        logic store;
        logic clr_word;
        logic inc_word;
        logic rd_word;
        logic load_out;
    } isfd_cmd_t;

    typedef struct packed {
        logic hdr1_hit;
        logic hdr2_hit;
        logic trl1_hit;
        logic trl2_hit;
        logic count_last;
        logic word_last;
        logic out_take;
    } isfd_sts_t;

endpackage

FILE: rtl/core/isfd_ram.sv
module isfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/isfd_ctrl.sv
module isfd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  isfd_pkg::isfd_sts_t sts,
    output isfd_pkg::isfd_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_HUNT1  = 8'b0000_0001,
        S_HUNT2  = 8'b0000_0010,
        S_DATA   = 8'b0000_0100,
        S_TRAIL1 = 8'b0000_1000,
        S_TRAIL2 = 8'b0001_0000,
        S_READ   = 8'b0010_0000,
        S_LOAD   = 8'b0100_0000,
        S_WAIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready;
    logic   acc;

    assign ready    = (state_reg == S_HUNT1) || (state_reg == S_HUNT2) ||
                      (state_reg == S_DATA)  || (state_reg == S_TRAIL1) ||
                      (state_reg == S_TRAIL2);
    assign s_tready = ready;
    assign acc      = s_tvalid && ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_HUNT1:
            begin
                if (acc)
                begin
                    state_next = sts.hdr1_hit ? S_HUNT2 : S_HUNT1;
                end
            end
            S_HUNT2:
            begin
                if (acc)
                begin
                    cmd.clr_count = sts.hdr2_hit;
                    state_next    = sts.hdr2_hit ? S_DATA : S_HUNT1;
                end
            end
            S_DATA:
            begin
                if (acc)
                begin
                    cmd.store = 1'b1;
                    if (sts.count_last)
                    begin
                        state_next = S_TRAIL1;
                    end
                end
            end
            S_TRAIL1:
            begin
                if (acc)
                begin
                    state_next = sts.trl1_hit ? S_TRAIL2 : S_HUNT1;
                end
            end
            S_TRAIL2:
            begin
                if (acc)
                begin
                    cmd.clr_word = sts.trl2_hit;
                    state_next   = sts.trl2_hit ? S_READ : S_HUNT1;
                end
            end
            S_READ:
            begin
                cmd.rd_word = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_out = 1'b1;
                state_next   = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.out_take)
                begin
                    if (sts.word_last)
                    begin
                        state_next = S_HUNT1;
                    end
                    else
                    begin
                        cmd.inc_word = 1'b1;
                        state_next   = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/isfd_dpath.sv
module isfd_dpath #(
    parameter int PAYLOAD_BYTES = isfd_pkg::PAYLOAD_BYTES_DEF,
    parameter int WORD_COUNT    = isfd_pkg::WORD_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [isfd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [isfd_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic [isfd_pkg::BYTE_W-1:0]         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [isfd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    input  isfd_pkg::isfd_cmd_t                 cmd,
    output isfd_pkg::isfd_sts_t                 sts
);

    localparam int CW          = $clog2(PAYLOAD_BYTES);
    localparam int STORE_WORDS = (PAYLOAD_BYTES + isfd_pkg::LANES - 1) / isfd_pkg::LANES;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int LW          = $clog2(isfd_pkg::LANES);
    localparam int PW          = isfd_pkg::WORD_IDX_W + LW + 1;

    logic [isfd_pkg::BYTE_W-1:0]     hdr_first_reg;
    logic [isfd_pkg::BYTE_W-1:0]     hdr_second_reg;
    logic [isfd_pkg::BYTE_W-1:0]     trl_first_reg;
    logic [isfd_pkg::BYTE_W-1:0]     trl_second_reg;
    logic [CW-1:0]                   cnt_reg;
    logic [isfd_pkg::WORD_IDX_W-1:0] word_reg;
    logic [isfd_pkg::LANES-1:0]      lane_ok_reg;
    logic [isfd_pkg::LANES-1:0]      lane_ok_next;
    logic                            out_valid_reg;
    logic [isfd_pkg::WORD_W-1:0]     out_word_reg;
    logic [isfd_pkg::WORD_IDX_W-1:0] out_idx_reg;
    logic                            out_last_reg;
    logic [isfd_pkg::WORD_W-1:0]     word_masked;
    logic [LW-1:0]                   wr_lane;
    logic [AW-1:0]                   wr_addr;
    logic [AW-1:0]                   rd_addr;
    logic                            count_last;
    logic                            word_last;

    assign count_last = (cnt_reg == CW'(PAYLOAD_BYTES - 1));
    assign word_last  = (word_reg == isfd_pkg::WORD_IDX_W'(WORD_COUNT - 1));
    assign wr_lane    = cnt_reg[LW-1:0];
    assign wr_addr    = AW'(cnt_reg >> LW);
    assign rd_addr    = ({1'b0, word_reg} < (isfd_pkg::WORD_IDX_W + 1)'(STORE_WORDS)) ?
                        AW'(word_reg) : '0;

    assign sts.hdr1_hit   = (s_tdata == hdr_first_reg);
    assign sts.hdr2_hit   = (s_tdata == hdr_second_reg);
    assign sts.trl1_hit   = (s_tdata == trl_first_reg);
    assign sts.trl2_hit   = (s_tdata == trl_second_reg);
    assign sts.count_last = count_last;
    assign sts.word_last  = word_last;
    assign sts.out_take   = out_valid_reg && m_tready;

    // one ram per byte lane so a whole word reads in one access
    for (genvar k = 0; k < isfd_pkg::LANES; k++)
    begin : g_lane
        logic [isfd_pkg::BYTE_W-1:0] rdata;

        isfd_ram #(
            .WIDTH(isfd_pkg::BYTE_W),
            .DEPTH(STORE_WORDS)
        ) u_ram (
            .clk  (clk),
            .we   (cmd.store && (wr_lane == LW'(k))),
            .waddr(wr_addr),
            .wdata(s_tdata),
            .re   (cmd.rd_word),
            .raddr(rd_addr),
            .rdata(rdata)
        );

        // bytes past the payload read as zero
        assign lane_ok_next[k] = ({1'b0, word_reg, LW'(k)} < PW'(PAYLOAD_BYTES));
        assign word_masked[k*isfd_pkg::BYTE_W +: isfd_pkg::BYTE_W] =
            lane_ok_reg[k] ? rdata : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= isfd_pkg::HDR_FIRST_RST;
            hdr_second_reg <= isfd_pkg::HDR_SECOND_RST;
            trl_first_reg  <= isfd_pkg::TRL_FIRST_RST;
            trl_second_reg <= isfd_pkg::TRL_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                isfd_pkg::REG_HDR_FIRST:  hdr_first_reg  <= cfg_wdata;
                isfd_pkg::REG_HDR_SECOND: hdr_second_reg <= cfg_wdata;
                isfd_pkg::REG_TRL_FIRST:  trl_first_reg  <= cfg_wdata;
                isfd_pkg::REG_TRL_SECOND: trl_second_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_count)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.store)
            begin
                cnt_reg <= count_last ? '0 : cnt_reg + 1'b1;
            end

            if (cmd.clr_word)
            begin
                word_reg <= '0;
            end
            else if (cmd.inc_word)
            begin
                word_reg <= word_reg + 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_word)
        begin
            lane_ok_reg <= lane_ok_next;
        end
        if (cmd.load_out)
        begin
            out_word_reg <= word_masked;
            out_idx_reg  <= word_reg;
            out_last_reg <= word_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{isfd_pkg::OUT_PAD_W{1'b0}}, out_idx_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/core/imu_serial_frame_deframer_unit.sv
// serial byte frame deframer
// s_* : one received byte per request, tdata[7:0] = received_byte
// m_* : payload words, tdata[31:0] = payload_word, [35:32] = word_index,
//       upper bits zero; tlast marks the final word of a frame
// cfg_* : write-only registers, 0 header first, 1 header second,
//         2 trailer first, 3 trailer second
// bytes are taken one per cycle while the parser hunts, collects the payload
// or checks the trailer; a mismatching header or trailer byte returns it to
// hunting without rescanning that byte
// after the second trailer byte the controller addresses the byte-lane rams
// in S_READ and loads the registered read into the output register in S_LOAD;
// each further word is read the same way only after the previous one is taken,
// so a single word is in flight at a time; s_tready stays low for the
// whole burst and comes back the cycle after the last word is taken
// a stalled m_tready simply holds the word and the burst
// reset restores the default header and trailer values and hunting; payload
// storage is not cleared, every frame overwrites it before it is read
module imu_serial_frame_deframer_unit #(
    parameter int PAYLOAD_BYTES = isfd_pkg::PAYLOAD_BYTES_DEF,
    parameter int WORD_COUNT    = isfd_pkg::WORD_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [isfd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [isfd_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [isfd_pkg::BYTE_W-1:0]      s_tdata,   // received_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [isfd_pkg::OUT_TDATA_W-1:0] m_tdata,   // payload_word, word_index
    output logic                             m_tlast
);

    isfd_pkg::isfd_cmd_t cmd;
    isfd_pkg::isfd_sts_t sts;

    isfd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    isfd_dpath #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .WORD_COUNT   (WORD_COUNT)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

FILE: rtl/core/isfd_checker.sv
module isfd_checker #(
    parameter int WORD_COUNT = isfd_pkg::WORD_COUNT_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [isfd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);

    // no byte is taken while a word is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !m_tvalid)
    else $error("byte accepted during word burst");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled word changed");

    // burst ends after the last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("word after frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
        (m_tdata[isfd_pkg::WORD_W +: isfd_pkg::WORD_IDX_W] ==
         isfd_pkg::WORD_IDX_W'(WORD_COUNT - 1)))
    else $error("last word has wrong index");

endmodule

bind imu_serial_frame_deframer_unit isfd_checker #(
    .WORD_COUNT(WORD_COUNT)
) u_isfd_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

FILE: sim/imu_serial_frame_deframer_unit_tb.sv
`timescale 1ns / 100ps

typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    COLLECT,
    TRAIL_FIRST,
    TRAIL_SECOND
} parse_phase_t;

typedef enum int {
    GOOD_FRAME,
    BAD_HEADER,
    BAD_TRAILER_FIRST,
    BAD_TRAILER_SECOND
} frame_kind_t;

typedef struct packed {
    logic [isfd_pkg::WORD_W-1:0]     payload_word;
    logic [isfd_pkg::WORD_IDX_W-1:0] word_index;
    logic                            last_word;
} frame_word_t;

class frame_word_scoreboard;
    localparam int PAYLOAD_BYTES = isfd_pkg::PAYLOAD_BYTES_DEF;
    localparam int WORD_COUNT    = isfd_pkg::WORD_COUNT_DEF;

    logic [7:0]   hdr1;
    logic [7:0]   hdr2;
    logic [7:0]   trl1;
    logic [7:0]   trl2;
    parse_phase_t phase;
    int           stored;
    logic [7:0]   payload [PAYLOAD_BYTES];
    frame_word_t  pending_words [$];
    int           mismatches;

    function new();
        hdr1       = isfd_pkg::HDR_FIRST_RST;
        hdr2       = isfd_pkg::HDR_SECOND_RST;
        trl1       = isfd_pkg::TRL_FIRST_RST;
        trl2       = isfd_pkg::TRL_SECOND_RST;
        phase      = HUNT_FIRST;
        stored     = 0;
        mismatches = 0;
        foreach (payload[i]) payload[i] = 8'h00;
    endfunction

    function void set_register(logic [isfd_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
        case (idx)
            isfd_pkg::REG_HDR_FIRST:  hdr1 = value;
            isfd_pkg::REG_HDR_SECOND: hdr2 = value;
            isfd_pkg::REG_TRL_FIRST:  trl1 = value;
            isfd_pkg::REG_TRL_SECOND: trl2 = value;
            default: ;
        endcase
    endfunction

    function void queue_frame_words();
        frame_word_t fw;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            for (int k = 0; k < isfd_pkg::LANES; k++)
                fw.payload_word[8*k +: 8] = payload[w*isfd_pkg::LANES + k];
            fw.word_index = w[isfd_pkg::WORD_IDX_W-1:0];
            fw.last_word  = (w == WORD_COUNT - 1);
            pending_words.insert(pending_words.size(), fw);
        end
    endfunction

    function void accept_byte(logic [7:0] b);
        case (phase)
            HUNT_SECOND:
            begin
                if (b == hdr2)
                begin
                    stored = 0;
                    phase  = COLLECT;
                end
                else
                    phase = HUNT_FIRST;
            end
            COLLECT:
            begin
                payload[stored] = b;
                stored++;
                if (stored >= PAYLOAD_BYTES)
                begin
                    stored = 0;
                    phase  = TRAIL_FIRST;
                end
            end
            TRAIL_FIRST:
                phase = (b == trl1) ? TRAIL_SECOND : HUNT_FIRST;
            TRAIL_SECOND:
            begin
                phase = HUNT_FIRST;
                if (b == trl2)
                    queue_frame_words();
            end
            default:
                phase = (b == hdr1) ? HUNT_SECOND : HUNT_FIRST;
        endcase
    endfunction

    function void check_word(logic [isfd_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
        frame_word_t got;
        frame_word_t want;
        got.payload_word = tdata[isfd_pkg::WORD_W-1:0];
        got.word_index   = tdata[isfd_pkg::WORD_W +: isfd_pkg::WORD_IDX_W];
        got.last_word    = tlast;
        if (pending_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: got word %h index %0d last %0b",
                         got.payload_word, got.word_index, got.last_word);
        end
        else
        begin
            want = pending_words.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"word mismatch: expected %h index %0d last %0b, ",
                              "got %h index %0d last %0b"},
                             want.payload_word, want.word_index, want.last_word,
                             got.payload_word, got.word_index, got.last_word);
            end
        end
    endfunction
endclass

module imu_serial_frame_deframer_unit_tb;

    localparam int HOLD_CYCLES = 400;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 cfg_we    = 1'b0;
    logic [isfd_pkg::CFG_IDX_W-1:0]       cfg_addr  = '0;
    logic [isfd_pkg::BYTE_W-1:0]          cfg_wdata = '0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [isfd_pkg::BYTE_W-1:0]          s_tdata   = '0;   // received_byte
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [isfd_pkg::OUT_TDATA_W-1:0]     m_tdata;          // payload_word, word_index
    logic                                 m_tlast;

    frame_word_scoreboard tracker;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   bytes_sent    = 0;
    logic hold_go       = 1'b0;
    logic hold_done     = 1'b0;

    imu_serial_frame_deframer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // word side: check, then pick next tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_word(m_tdata, m_tlast);
        m_tready <= !(hold_go && !hold_done) && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off
    initial
    begin
        wait (hold_go);
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0] other_than(logic [7:0] v);
        logic [7:0] r;
        r = v + 8'($urandom_range(1, 255));
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.accept_byte(b);
        bytes_sent++;
    endtask

    task automatic push_frame(input frame_kind_t kind, input bit extremes);
        logic [7:0] b;
        push_byte(tracker.hdr1);
        if (kind == BAD_HEADER)
        begin
            push_byte(other_than(tracker.hdr2));
            return;
        end
        push_byte(tracker.hdr2);
        for (int i = 0; i < isfd_pkg::PAYLOAD_BYTES_DEF; i++)
        begin
            if (extremes && i < 2 * isfd_pkg::LANES)
                b = (i < isfd_pkg::LANES) ? 8'h00 : 8'hFF;
            else
                case ($urandom_range(7))
                    0:       b = tracker.hdr1;
                    1:       b = tracker.trl1;
                    2:       b = tracker.trl2;
                    default: b = 8'($urandom);
                endcase
            push_byte(b);
        end
        if (kind == BAD_TRAILER_FIRST)
        begin
            push_byte(other_than(tracker.trl1));
            return;
        end
        push_byte(tracker.trl1);
        push_byte(kind == BAD_TRAILER_SECOND ? other_than(tracker.trl2) : tracker.trl2);
    endtask

    task automatic push_random();
        int r;
        r = $urandom_range(99);
        if (r < 64)
            push_frame(GOOD_FRAME, $urandom_range(9) == 0);
        else if (r < 72)
            push_frame(BAD_HEADER, 1'b0);
        else if (r < 80)
            push_frame(BAD_TRAILER_FIRST, 1'b0);
        else if (r < 88)
            push_frame(BAD_TRAILER_SECOND, 1'b0);
        else
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
    endtask

    // stop sending and let every expected word drain
    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (tracker.pending_words.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_one(input logic [isfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.set_register(idx, value);
    endtask

    task automatic program_regs(input logic [7:0] h1, input logic [7:0] h2,
                                input logic [7:0] t1, input logic [7:0] t2);
        write_one(isfd_pkg::REG_HDR_FIRST, h1);
        write_one(isfd_pkg::REG_HDR_SECOND, h2);
        write_one(isfd_pkg::REG_TRL_FIRST, t1);
        write_one(isfd_pkg::REG_TRL_SECOND, t2);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_idle_pct = 88;

        // reset values, broken headers, no rescan of a failed byte
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(isfd_pkg::HDR_FIRST_RST);
        push_byte(8'h00);
        push_byte(isfd_pkg::HDR_FIRST_RST);
        push_byte(isfd_pkg::HDR_FIRST_RST);
        push_byte(isfd_pkg::HDR_SECOND_RST);
        push_byte(isfd_pkg::TRL_FIRST_RST);
        push_byte(isfd_pkg::TRL_SECOND_RST);
        push_frame(GOOD_FRAME, 1'b1);

        settle();
        program_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
        while (bytes_sent < 180)
            push_random();

        settle();
        send_idle_pct = 88;
        recv_idle_pct = 10;
        program_regs(8'hFF, 8'hFF, 8'h00, 8'h00);
        while (bytes_sent < 260)
            push_random();
        settle();
        while (bytes_sent < 330)
            push_random();

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        hold_go <= 1'b1;
        push_frame(GOOD_FRAME, 1'b0);
        push_frame(GOOD_FRAME, 1'b0);
        while (bytes_sent < 400)
            push_random();
        settle();
        program_regs(isfd_pkg::HDR_FIRST_RST, isfd_pkg::HDR_SECOND_RST,
                     isfd_pkg::TRL_FIRST_RST, isfd_pkg::TRL_SECOND_RST);
        while (bytes_sent < 470)
            push_random();

        settle();
        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/isfd_pkg.sv
rtl/core/isfd_ram.sv
rtl/core/isfd_ctrl.sv
rtl/core/isfd_dpath.sv
rtl/core/imu_serial_frame_deframer_unit.sv
rtl/core/isfd_checker.sv
sim/imu_serial_frame_deframer_unit_tb.sv
